[sv/hamming_sec_row_decoder_core_assert.svh]
// Assertion macros shared by the checkers of the Hamming row decoder.
// Depends on nothing; files that assert include it by name.
`ifndef HAMMING_SEC_ROW_DECODER_CORE_ASSERT_SVH
`define HAMMING_SEC_ROW_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define HSRD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsrd assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define HSRD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsrd assertion failed");

`endif

[sv/hsrd_pkg.sv]
// Package of the Hamming row decoder: field widths, reset values and the
// constant functions that describe the code layout. Depends on nothing.
package hsrd_pkg;

   localparam int CW_WIDTH          = 62;
   localparam int DATA_WIDTH        = 56;
   localparam int SYN_WIDTH         = 6;
   localparam int LEN_WIDTH         = 6;
   localparam int ROW_BYTES_WIDTH   = 3;
   localparam int BITS_PER_BYTE     = 8;
   localparam int DEF_MAX_ROW_BYTES = 7;

   localparam logic [ROW_BYTES_WIDTH-1:0] ROW_BYTES_RESET = ROW_BYTES_WIDTH'(4);

   // Codeword length for a row of m bytes: 8*m data bits plus the least
   // number of check bits r with 2^r >= 8*m + r + 1.
   function automatic logic [LEN_WIDTH-1:0] code_len(input logic [ROW_BYTES_WIDTH-1:0] m);
      int r;
      r = 0;
      for (int k = 0; k <= SYN_WIDTH; k++) begin
         if ((1 << k) < BITS_PER_BYTE * int'(m) + k + 1) begin
            r = k + 1;
         end
      end
      return LEN_WIDTH'(BITS_PER_BYTE * int'(m) + r);
   endfunction

   // Bits of the codeword that feed syndrome bit k.
   function automatic logic [CW_WIDTH-1:0] syn_mask(input int k);
      logic [CW_WIDTH-1:0] mask;
      mask = '0;
      for (int i = 0; i < CW_WIDTH; i++) begin
         mask[i] = (((i + 1) >> k) & 1) == 1;
      end
      return mask;
   endfunction

   // Codeword position (from 1) of data bit d, skipping power-of-two positions.
   function automatic int data_pos(input int d);
      int cnt;
      int pos;
      cnt = 0;
      pos = 0;
      for (int p = 1; p <= CW_WIDTH; p++) begin
         if ((p & (p - 1)) != 0) begin
            if (cnt == d) begin
               pos = p;
            end
            cnt++;
         end
      end
      return pos;
   endfunction

endpackage

[sv/hsrd_if.sv]
// Valid/ready channel interfaces of the Hamming row decoder: the codeword
// request and the decoded response. Depends on hsrd_pkg.
interface hsrd_req_if;
   import hsrd_pkg::*;

   logic                valid;
   logic                ready;
   logic [CW_WIDTH-1:0] codeword;

   modport source (output valid, output codeword, input ready);
   modport sink   (input valid, input codeword, output ready);
endinterface

interface hsrd_rsp_if;
   import hsrd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] data_bytes;
   logic [SYN_WIDTH-1:0]  syndrome;
   logic                  corrected;
   logic                  syndrome_out_of_range;

   modport source (output valid, output data_bytes, output syndrome, output corrected,
                   output syndrome_out_of_range, input ready);
   modport sink   (input valid, input data_bytes, input syndrome, input corrected,
                   input syndrome_out_of_range, output ready);
endinterface

[sv/hamming_sec_row_decoder_core.sv]
// Hamming single-error-correcting row decoder, top level.
// Depends on hsrd_pkg and the channel interfaces in hsrd_if.sv.
//
// The block takes one received codeword per request transaction and returns
// one response transaction holding the corrected, byte-packed data, the
// syndrome and two flags. A row holds row_bytes data bytes (written through
// the csr port while the block is idle; 0 acts as 1, values above
// MAX_ROW_BYTES act as MAX_ROW_BYTES). Codeword bit i is position i+1,
// check bits sit at power-of-two positions, and bits above the codeword
// length are ignored. A nonzero syndrome within the length flips that bit and
// raises corrected; a syndrome beyond the length raises
// syndrome_out_of_range and nothing is changed. The datapath is a pipeline of
// three register stages (length masking, syndrome XOR trees, correction and
// packing). A request accepted at a clock edge is registered by the masking
// stage, then the syndrome stage, then the correction stage, which drives the
// response port; a new request is accepted every cycle unless stalled. Each
// stage holds its item while the stage after it is full and stalled, so a busy
// response port stops the pipeline only once all three stages are occupied.
module hamming_sec_row_decoder_core #(
   parameter int MAX_ROW_BYTES = hsrd_pkg::DEF_MAX_ROW_BYTES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   hsrd_req_if.sink                             req,
   hsrd_rsp_if.source                           rsp,
   input  logic                                 csr_wr_en,
   input  logic [hsrd_pkg::ROW_BYTES_WIDTH-1:0] csr_wr_data
);
   import hsrd_pkg::*;

   // Configuration register and the codeword length it selects.
   logic [ROW_BYTES_WIDTH-1:0] row_bytes_ff;
   logic [ROW_BYTES_WIDTH-1:0] row_bytes_in;
   logic [ROW_BYTES_WIDTH-1:0] eff_bytes;
   logic [LEN_WIDTH-1:0]       in_len;

   // Stage 1: codeword with bits above the length cleared.
   logic                  s1_valid_ff;
   logic [CW_WIDTH-1:0]   s1_cw_ff;
   logic [CW_WIDTH-1:0]   s1_cw_in;
   logic [LEN_WIDTH-1:0]  s1_len_ff;

   // Stage 2: codeword and its syndrome.
   logic                  s2_valid_ff;
   logic [CW_WIDTH-1:0]   s2_cw_ff;
   logic [SYN_WIDTH-1:0]  s2_syn_ff;
   logic [SYN_WIDTH-1:0]  s2_syn_in;
   logic [LEN_WIDTH-1:0]  s2_len_ff;

   // Stage 3: the response register.
   logic                  s3_valid_ff;
   logic [DATA_WIDTH-1:0] s3_data_ff;
   logic [DATA_WIDTH-1:0] s3_data_in;
   logic [SYN_WIDTH-1:0]  s3_syn_ff;
   logic                  s3_fix_ff;
   logic                  s3_fix_in;
   logic                  s3_oor_ff;
   logic                  s3_oor_in;
   logic [CW_WIDTH-1:0]   fixed_cw;

   // A stage may load when it is empty or when its content moves on.
   logic adv1;
   logic adv2;
   logic adv3;

   assign adv3      = !s3_valid_ff || rsp.ready;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req.ready = adv1;

   // Configuration write and the effective row size.
   always_comb begin
      row_bytes_in = csr_wr_en ? csr_wr_data : row_bytes_ff;
      if (row_bytes_ff == '0) begin
         eff_bytes = ROW_BYTES_WIDTH'(1);
      end else if (row_bytes_ff > ROW_BYTES_WIDTH'(MAX_ROW_BYTES)) begin
         eff_bytes = ROW_BYTES_WIDTH'(MAX_ROW_BYTES);
      end else begin
         eff_bytes = row_bytes_ff;
      end
      in_len = code_len(eff_bytes);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= ROW_BYTES_RESET;
      end else begin
         row_bytes_ff <= row_bytes_in;
      end
   end

   // Stage 1 logic: drop every bit whose position lies above the length.
   always_comb begin
      for (int i = 0; i < CW_WIDTH; i++) begin
         s1_cw_in[i] = req.codeword[i] && (LEN_WIDTH'(i) < in_len);
      end
   end

   // Stage 2 logic: syndrome bit k is the parity of all positions with bit k set.
   always_comb begin
      for (int k = 0; k < SYN_WIDTH; k++) begin
         s2_syn_in[k] = ^(s1_cw_ff & syn_mask(k));
      end
   end

   // Stage 3 logic: correct one bit if the syndrome names a real position,
   // then gather the data positions into bytes, first received bit as MSB.
   always_comb begin
      s3_fix_in = (s2_syn_ff != '0) && (LEN_WIDTH'(s2_syn_ff) <= s2_len_ff);
      s3_oor_in = (s2_syn_ff != '0) && (LEN_WIDTH'(s2_syn_ff) > s2_len_ff);
      for (int i = 0; i < CW_WIDTH; i++) begin
         fixed_cw[i] = s2_cw_ff[i] ^ (s3_fix_in && (s2_syn_ff == SYN_WIDTH'(i + 1)));
      end
      for (int d = 0; d < DATA_WIDTH; d++) begin
         s3_data_in[(d / BITS_PER_BYTE) * BITS_PER_BYTE + BITS_PER_BYTE - 1
                    - (d % BITS_PER_BYTE)] = fixed_cw[data_pos(d) - 1];
      end
   end

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req.valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Payload of the three stages; loaded only when a valid item moves in.
   always_ff @(posedge clock) begin
      if (adv1 && req.valid) begin
         s1_cw_ff  <= s1_cw_in;
         s1_len_ff <= in_len;
      end
      if (adv2 && s1_valid_ff) begin
         s2_cw_ff  <= s1_cw_ff;
         s2_syn_ff <= s2_syn_in;
         s2_len_ff <= s1_len_ff;
      end
      if (adv3 && s2_valid_ff) begin
         s3_data_ff <= s3_data_in;
         s3_syn_ff  <= s2_syn_ff;
         s3_fix_ff  <= s3_fix_in;
         s3_oor_ff  <= s3_oor_in;
      end
   end

   assign rsp.valid                 = s3_valid_ff;
   assign rsp.data_bytes            = s3_data_ff;
   assign rsp.syndrome              = s3_syn_ff;
   assign rsp.corrected             = s3_fix_ff;
   assign rsp.syndrome_out_of_range = s3_oor_ff;

endmodule

[sv/hsrd_checker.sv]
// Port-level checker of the Hamming row decoder and its bind to the top level.
// Depends on hsrd_pkg and hamming_sec_row_decoder_core_assert.svh.
`include "hamming_sec_row_decoder_core_assert.svh"

module hsrd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [hsrd_pkg::DATA_WIDTH-1:0]  rsp_data_bytes,
   input logic [hsrd_pkg::SYN_WIDTH-1:0]   rsp_syndrome,
   input logic                             rsp_corrected,
   input logic                             rsp_syndrome_out_of_range
);
   import hsrd_pkg::*;

   logic [DATA_WIDTH+SYN_WIDTH+1:0] rsp_payload;
   logic                            rsp_stalled;
   logic                            rsp_any_flag;
   logic                            rsp_both_flags;

   assign rsp_payload    = {rsp_data_bytes, rsp_syndrome, rsp_corrected,
                            rsp_syndrome_out_of_range};
   assign rsp_stalled    = rsp_valid && !rsp_ready;
   assign rsp_any_flag   = rsp_corrected || rsp_syndrome_out_of_range;
   assign rsp_both_flags = rsp_corrected && rsp_syndrome_out_of_range;

   // A stalled response stays offered.
   `HSRD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid)

   // A stalled response keeps its payload.
   `HSRD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stalled, $stable(rsp_payload))

   // A transaction is either corrected or out of range, never both.
   `HSRD_ASSERT_NOW(a_flags_excl, clock, reset, rsp_valid, !rsp_both_flags)

   // A zero syndrome means nothing was seen, so neither flag is raised.
   `HSRD_ASSERT_NOW(a_zero_syn, clock, reset, rsp_valid && (rsp_syndrome == '0), !rsp_any_flag)

endmodule

bind hamming_sec_row_decoder_core hsrd_checker u_hsrd_checker (
   .clock                     (clock),
   .reset                     (reset),
   .rsp_valid                 (rsp.valid),
   .rsp_ready                 (rsp.ready),
   .rsp_data_bytes            (rsp.data_bytes),
   .rsp_syndrome              (rsp.syndrome),
   .rsp_corrected             (rsp.corrected),
   .rsp_syndrome_out_of_range (rsp.syndrome_out_of_range)
);

[tb/tb_top.sv]
// Self-checking testbench for hamming_sec_row_decoder_core: random and directed codewords,
// predicted in-bench, compared against every response transaction.
// Depends on hsrd_pkg and the channel interfaces in hsrd_if.sv.
`timescale 1ns / 100ps

module tb_top;
   import hsrd_pkg::*;

   // The DUT is built with its default row size limit, so the bench uses the same.
   localparam int MAX_ROWS       = DEF_MAX_ROW_BYTES;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int ITEMS_PER_MODE = 37;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] data_bytes;
      logic [SYN_WIDTH-1:0]  syndrome;
      logic                  corrected;
      logic                  syndrome_out_of_range;
   } row_result_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_wr_en;
   logic [ROW_BYTES_WIDTH-1:0] csr_wr_data;
   logic                       holdoff_kick;

   hsrd_req_if req_ch ();
   hsrd_rsp_if rsp_ch ();

   hamming_sec_row_decoder_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Codewords waiting for the driver, and the decoded rows expected back, keyed
   // by the order in which their request transactions were accepted.
   logic [CW_WIDTH-1:0] codeword_queue[$];
   row_result_type      expected_rows[int];

   // The row size the DUT holds; changed only while nothing is in flight.
   logic [ROW_BYTES_WIDTH-1:0] row_model = ROW_BYTES_RESET;

   // Accepted and checked counts move with nonblocking updates, so every clocked
   // process sees the values from before the current edge.
   int n_accepted  = 0;
   int n_checked   = 0;
   int n_queued    = 0;
   int n_writes    = 0;
   int n_fixed     = 0;
   int n_oor       = 0;
   int error_count = 0;
   int holdoff_left = 0;

   // Percent chance per cycle that the sender idles or the receiver stalls.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < 40) begin
         $display("MISMATCH: %s", msg);
      end
      error_count++;
   endtask

   // ---------------------------------------------------------------------------
   // Code layout helpers. A row of m bytes uses the least r check bits with
   // 2^r >= 8m + r + 1; check bits sit at power-of-two positions.
   // ---------------------------------------------------------------------------
   function automatic int eff_row_bytes(input logic [ROW_BYTES_WIDTH-1:0] rb);
      int m;
      m = int'(rb);
      // A zero row size acts as one byte, and sizes beyond the limit are clipped.
      if (m == 0) begin
         m = 1;
      end
      if (m > MAX_ROWS) begin
         m = MAX_ROWS;
      end
      return m;
   endfunction

   function automatic int code_length(input int m);
      int r;
      r = 0;
      while ((1 << r) < BITS_PER_BYTE * m + r + 1) begin
         r++;
      end
      return BITS_PER_BYTE * m + r;
   endfunction

   function automatic bit is_check_pos(input int p);
      return (p & (p - 1)) == 0;
   endfunction

   // Syndrome is the XOR of the positions of all set bits within the codeword.
   function automatic logic [SYN_WIDTH-1:0] row_syndrome(input logic [CW_WIDTH-1:0] cw,
                                                         input int len);
      logic [SYN_WIDTH-1:0] s;
      s = '0;
      for (int p = 1; p <= len; p++) begin
         if (cw[p-1]) begin
            s ^= SYN_WIDTH'(p);
         end
      end
      return s;
   endfunction

   // Predicted response for one codeword at the given row size setting.
   function automatic row_result_type decode_row(input logic [CW_WIDTH-1:0] cw_in,
                                                 input logic [ROW_BYTES_WIDTH-1:0] rb);
      row_result_type       res;
      logic [CW_WIDTH-1:0]  cw;
      logic [SYN_WIDTH-1:0] syn;
      int                   len;
      int                   di;
      res = '0;
      cw  = cw_in;
      len = code_length(eff_row_bytes(rb));
      // Bits above the codeword length never reach the syndrome.
      syn = row_syndrome(cw, len);
      res.syndrome = syn;
      if (syn != '0) begin
         if (int'(syn) <= len) begin
            cw[int'(syn) - 1] = ~cw[int'(syn) - 1];
            res.corrected = 1'b1;
         end else begin
            res.syndrome_out_of_range = 1'b1;
         end
      end
      // Data bits fill each byte from its MSB down, in received order.
      di = 0;
      for (int p = 1; p <= len; p++) begin
         if (!is_check_pos(p)) begin
            if (cw[p-1]) begin
               res.data_bytes[BITS_PER_BYTE * (di / BITS_PER_BYTE) + 7
                              - (di % BITS_PER_BYTE)] = 1'b1;
            end
            di++;
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers: encoding of clean rows and error injection.
   // ---------------------------------------------------------------------------
   function automatic logic [CW_WIDTH-1:0] rand_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[CW_WIDTH-1:0];
   endfunction

   function automatic logic [CW_WIDTH-1:0] encode_row(input logic [DATA_WIDTH-1:0] data,
                                                      input int m);
      logic [CW_WIDTH-1:0]  cw;
      logic [SYN_WIDTH-1:0] s;
      int                   len;
      int                   di;
      cw  = '0;
      len = code_length(m);
      di  = 0;
      for (int p = 1; p <= len; p++) begin
         if (!is_check_pos(p)) begin
            cw[p-1] = data[BITS_PER_BYTE * (di / BITS_PER_BYTE) + 7 - (di % BITS_PER_BYTE)];
            di++;
         end
      end
      // Each check bit only feeds its own syndrome bit, so setting it cancels that bit.
      s = row_syndrome(cw, len);
      for (int k = 0; k < SYN_WIDTH; k++) begin
         if (s[k]) begin
            cw[(1 << k) - 1] = 1'b1;
         end
      end
      return cw;
   endfunction

   function automatic logic [CW_WIDTH-1:0] flip_bits(input logic [CW_WIDTH-1:0] cw,
                                                     input int p1, input int p2);
      if (p1 != 0) begin
         cw[p1-1] = ~cw[p1-1];
      end
      if (p2 != 0) begin
         cw[p2-1] = ~cw[p2-1];
      end
      return cw;
   endfunction

   // Random garbage in the bits above the codeword length only.
   function automatic logic [CW_WIDTH-1:0] junk_above(input int len);
      logic [63:0] low_mask;
      logic [63:0] w;
      low_mask = (64'd1 << len) - 64'd1;
      w = {$urandom, $urandom};
      return CW_WIDTH'(w & ~low_mask);
   endfunction

   function automatic logic [DATA_WIDTH-1:0] rand_data(input int m);
      logic [63:0] w;
      w = {$urandom, $urandom};
      return DATA_WIDTH'(w & ((64'd1 << (BITS_PER_BYTE * m)) - 64'd1));
   endfunction

   // Mostly well-formed rows with zero, one or two bit errors, plus a share of
   // rows with garbage above the codeword and fully random words.
   function automatic logic [CW_WIDTH-1:0] make_random_item(input int m);
      logic [CW_WIDTH-1:0] cw;
      int                  len;
      int                  kind;
      int                  p1;
      int                  p2;
      len  = code_length(m);
      kind = $urandom_range(99);
      if (kind < 15) begin
         return rand_word();
      end
      cw = encode_row(rand_data(m), m);
      p1 = $urandom_range(len, 1);
      do begin
         p2 = $urandom_range(len, 1);
      end while (p2 == p1);
      if (kind < 35) begin
         return cw;
      end else if (kind < 75) begin
         return flip_bits(cw, p1, 0);
      end else if (kind < 87) begin
         return flip_bits(cw, p1, p2);
      end
      return flip_bits(cw, $urandom_range(1) ? p1 : 0, 0) | junk_above(len);
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: offers queued codewords, holds each until it is taken, and
   // records the predicted response when the request transaction completes.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid    <= 1'b0;
         req_ch.codeword <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_rows[n_accepted] = decode_row(req_ch.codeword, row_model);
            n_accepted <= n_accepted + 1;
         end
         // A new codeword may be offered only once the current one is gone.
         if (!req_ch.valid || req_ch.ready) begin
            if (codeword_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid    <= 1'b1;
               req_ch.codeword <= codeword_queue.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here and started by a one-cycle kick.
   always @(posedge clock) begin
      if (reset) begin
         holdoff_left <= 0;
      end else if (holdoff_kick) begin
         holdoff_left <= HOLDOFF_CYCLES;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Response monitor: checks each response transaction against the oldest
   // prediction, field by field, and randomly stalls the response channel.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : response_monitor
      row_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (n_checked == n_accepted) begin
               report_mismatch($sformatf("response with no codeword outstanding, data %h",
                                         rsp_ch.data_bytes));
            end else begin
               want = expected_rows[n_checked];
               if (rsp_ch.data_bytes !== want.data_bytes) begin
                  report_mismatch($sformatf("row %0d data_bytes got %h want %h", n_checked,
                                            rsp_ch.data_bytes, want.data_bytes));
               end
               if (rsp_ch.syndrome !== want.syndrome) begin
                  report_mismatch($sformatf("row %0d syndrome got %0d want %0d", n_checked,
                                            rsp_ch.syndrome, want.syndrome));
               end
               if (rsp_ch.corrected !== want.corrected) begin
                  report_mismatch($sformatf("row %0d corrected got %b want %b", n_checked,
                                            rsp_ch.corrected, want.corrected));
               end
               if (rsp_ch.syndrome_out_of_range !== want.syndrome_out_of_range) begin
                  report_mismatch($sformatf("row %0d out_of_range got %b want %b", n_checked,
                                            rsp_ch.syndrome_out_of_range,
                                            want.syndrome_out_of_range));
               end
               if (want.corrected) begin
                  n_fixed++;
               end
               if (want.syndrome_out_of_range) begin
                  n_oor++;
               end
               expected_rows.delete(n_checked);
               n_checked <= n_checked + 1;
            end
         end
         rsp_ch.ready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencer tasks.
   // ---------------------------------------------------------------------------
   task automatic queue_item(input logic [CW_WIDTH-1:0] cw);
      codeword_queue.insert(codeword_queue.size(), cw);
      n_queued++;
   endtask

   // Blocks until every queued codeword has come back and been checked.
   task automatic drain();
      do begin
         @(posedge clock);
      end while (n_checked != n_queued);
   endtask

   task automatic wait_sent();
      while (codeword_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Only called with the pipeline empty, so the model can switch at once.
   task automatic write_row_bytes(input logic [ROW_BYTES_WIDTH-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      row_model = value;
      n_writes++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence: reset, directed rows at the reset and the extreme row sizes, then random
   // phases over several row sizes, each phase cycling through idling modes.
   // ---------------------------------------------------------------------------
   initial begin : sequencer
      logic [DATA_WIDTH-1:0]      d;
      logic [CW_WIDTH-1:0]        enc;
      logic [ROW_BYTES_WIDTH-1:0] row_plan[9];
      int                         send_plan[4];
      int                         recv_plan[4];
      int                         m;

      row_plan  = '{3'd7, 3'd1, 3'd3, 3'd0, 3'd5, 3'd2, 3'd6, 3'd4, 3'd7};
      send_plan = '{0, 84, 0, 10};
      recv_plan = '{0, 0, 84, 10};

      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      holdoff_kick    = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed rows at the reset size of four bytes (length 38).
      set_idling(10, 10);
      d   = rand_data(4);
      enc = encode_row(d, 4);
      queue_item('0);
      queue_item({CW_WIDTH{1'b1}});
      queue_item(enc);
      queue_item(flip_bits(enc, 1, 0));
      queue_item(flip_bits(enc, 38, 0));
      queue_item(flip_bits(enc, 3, 0));
      // A double error whose syndrome (39) lies past the codeword.
      queue_item(flip_bits(enc, 33, 6));
      // Garbage above the codeword must not change anything.
      queue_item(enc | junk_above(38));
      drain();

      // Largest row: the codeword fills all 62 input bits.
      write_row_bytes(3'd7);
      enc = encode_row({DATA_WIDTH{1'b1}}, 7);
      queue_item('0);
      queue_item({CW_WIDTH{1'b1}});
      queue_item(enc);
      queue_item(flip_bits(enc, 62, 0));
      queue_item(flip_bits(enc, 32, 0));
      queue_item(flip_bits(enc, 61, 2));
      drain();

      // Smallest row: one byte, length 12.
      write_row_bytes(3'd1);
      enc = encode_row(DATA_WIDTH'(8'hA5), 1);
      queue_item(enc);
      queue_item(flip_bits(enc, 12, 0));
      queue_item(flip_bits(enc, 12, 1));
      queue_item(flip_bits(enc, 5, 0) | junk_above(12));
      drain();

      // A zero row size behaves as one byte.
      write_row_bytes(3'd0);
      enc = encode_row(DATA_WIDTH'(8'h3C), 1);
      queue_item(enc);
      queue_item(flip_bits(enc, 7, 0));
      queue_item(enc | junk_above(12));
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         write_row_bytes(row_plan[ph]);
         m = eff_row_bytes(row_model);
         for (int mode = 0; mode < 4; mode++) begin
            set_idling(send_plan[mode], recv_plan[mode]);
            for (int i = 0; i < ITEMS_PER_MODE; i++) begin
               queue_item(make_random_item(m));
            end
            wait_sent();
            // Once per phase the sender goes quiet until the pipeline is empty.
            if (mode == 1) begin
               drain();
            end
         end
         drain();

         if (ph == 0) begin
            // Back-pressure: the receiver holds off for a long stretch while the
            // sender keeps offering, so the pipeline fills and stalls requests.
            set_idling(0, 0);
            @(posedge clock);
            holdoff_kick <= 1'b1;
            @(posedge clock);
            holdoff_kick <= 1'b0;
            for (int i = 0; i < 40; i++) begin
               queue_item(make_random_item(m));
            end
            drain();
         end
      end

      // Let any stray response show up before the final verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (n_checked != n_accepted || expected_rows.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", n_accepted - n_checked));
      end

      $display("summary: %0d codewords checked, %0d row size writes, %0d corrected,",
               n_checked, n_writes, n_fixed);
      $display("summary: %0d out of range; idling none/sender/receiver/both, %0d-cycle hold-off",
               n_oor, HOLDOFF_CYCLES);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
